// ===== rtl/core/acws_pkg.sv =====
// Shared types, codes and helper functions of the 24-hour alarm clock.
// No dependencies; compile first.
package acws_pkg;

    // Event command codes
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_SNOOZE = 2'd3
    } cmd_t;

    // Adjust and toggle targets
    localparam logic [1:0] TGT_CLOCK     = 2'd0;
    localparam logic [1:0] TGT_ALARM_ONE = 2'd1;
    localparam logic [1:0] TGT_ALARM_TWO = 2'd2;

    // Adjust steps
    localparam logic [2:0] STEP_NONE     = 3'd0;
    localparam logic [2:0] STEP_HOUR_UP  = 3'd1;
    localparam logic [2:0] STEP_HOUR_DN  = 3'd2;
    localparam logic [2:0] STEP_MIN_UP   = 3'd3;
    localparam logic [2:0] STEP_MIN_DN   = 3'd4;

    // Sound start codes
    localparam logic [1:0] SOUND_NONE  = 2'd0;
    localparam logic [1:0] SOUND_TONE  = 2'd1;
    localparam logic [1:0] SOUND_RADIO = 2'd2;

    // Wrap limits and fixed values
    localparam logic [4:0] HOUR_MAX         = 5'd23;
    localparam logic [5:0] MIN_MAX          = 6'd59;
    localparam logic [5:0] SEC_MAX          = 6'd59;
    localparam logic [7:0] COUNT_MAX        = 8'd255;
    localparam logic [7:0] SNOOZE_LIMIT_RST = 8'd20;
    localparam logic [6:0] SHOWN_SCALE      = 7'd100;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
    } hm_t;

    // Architectural state of the clock
    typedef struct packed {
        hm_t             clk_time;
        logic [5:0]      seconds;
        hm_t [1:0]       wake;
        logic [1:0]      armed;
        logic            trig;
        logic            snooze;
        logic [1:0][7:0] counts;
        logic            tone;
    } state_t;

    // Outcome of one alarm match check
    typedef struct packed {
        logic       snooze;
        logic       trig;
        logic [7:0] count;
        logic       sound;
    } wake_t;

    // One result beat
    typedef struct packed {
        logic [4:0]  clock_hours;
        logic [5:0]  clock_minutes;
        logic [5:0]  clock_seconds;
        logic [11:0] shown_value;
        logic        alarm_one_armed;
        logic        alarm_two_armed;
        logic        ringing_latched;
        logic        snoozing;
        logic [1:0]  sound_start;
        logic        tone_mute;
    } result_t;

    // Step hours or minutes with wrap
    function automatic hm_t apply_step(hm_t cur, logic [2:0] step);
        hm_t nxt;
        nxt = cur;
        unique case (step)
            STEP_NONE: nxt = cur;
            STEP_HOUR_UP:
                nxt.hours = (cur.hours < HOUR_MAX) ? cur.hours + 5'd1 : 5'd0;
            STEP_HOUR_DN:
                nxt.hours = (cur.hours > 5'd0) ? cur.hours - 5'd1 : HOUR_MAX;
            STEP_MIN_UP:
                nxt.minutes = (cur.minutes < MIN_MAX) ? cur.minutes + 6'd1 : 6'd0;
            STEP_MIN_DN:
                nxt.minutes = (cur.minutes > 6'd0) ? cur.minutes - 6'd1 : MIN_MAX;
            default: nxt = cur;
        endcase
        return nxt;
    endfunction

    // Check one alarm against the clock; snooze and trigger flags chain
    function automatic wake_t check_wake(logic armed, hm_t wake, hm_t now,
                                         logic snooze, logic trig,
                                         logic [7:0] count, logic [7:0] limit);
        wake_t r;
        r.snooze = snooze;
        r.trig   = trig;
        r.count  = count;
        r.sound  = 1'b0;
        if (armed && (wake == now))
        begin
            if (snooze)
            begin
                if (count != COUNT_MAX)
                begin
                    r.count = count + 8'd1;
                end
            end
            else if (!trig)
            begin
                r.sound = 1'b1;
            end
            r.trig = 1'b1;
            // snooze expired: ring again
            if (r.count > limit)
            begin
                r.snooze = 1'b0;
                r.count  = 8'd0;
                r.sound  = 1'b1;
            end
        end
        return r;
    endfunction

    // Hours times 100 plus minutes
    function automatic logic [11:0] shown_of(hm_t t);
        return 12'(t.hours) * 12'(SHOWN_SCALE) + 12'(t.minutes);
    endfunction

endpackage

// ===== rtl/core/acws_ifs.sv =====
// Valid/ready channel interfaces for the alarm clock: event beats and
// status beats. No dependencies.
interface acws_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] target;
    logic [2:0] step;

    modport source (output valid, command, target, step, input ready);
    modport sink   (input valid, command, target, step, output ready);
endinterface

interface acws_status_if;
    logic        valid;
    logic        ready;
    logic [4:0]  clock_hours;
    logic [5:0]  clock_minutes;
    logic [5:0]  clock_seconds;
    logic [11:0] shown_value;
    logic        alarm_one_armed;
    logic        alarm_two_armed;
    logic        ringing_latched;
    logic        snoozing;
    logic [1:0]  sound_start;
    logic        tone_mute;

    modport source (output valid, clock_hours, clock_minutes, clock_seconds,
                    shown_value, alarm_one_armed, alarm_two_armed,
                    ringing_latched, snoozing, sound_start, tone_mute,
                    input ready);
    modport sink   (input valid, clock_hours, clock_minutes, clock_seconds,
                    shown_value, alarm_one_armed, alarm_two_armed,
                    ringing_latched, snoozing, sound_start, tone_mute,
                    output ready);
endinterface

// ===== rtl/core/acws_eval.sv =====
// Next-state and result logic for one event of the alarm clock.
// Depends on acws_pkg.
module acws_eval (
    input  acws_pkg::state_t  cur,
    input  logic [7:0]        snooze_limit,
    input  logic [1:0]        command,
    input  logic [1:0]        target,
    input  logic [2:0]        step,
    output acws_pkg::state_t  nxt,
    output acws_pkg::result_t res
);
    import acws_pkg::*;

    wake_t      w0;
    wake_t      w1;
    hm_t        shown;
    logic [1:0] sound;
    logic       mute;
    logic       sel;

    always_comb
    begin
        nxt   = cur;
        shown = cur.clk_time;
        sound = SOUND_NONE;
        mute  = 1'b0;
        sel   = (target == TGT_ALARM_TWO);
        w0    = '0;
        w1    = '0;

        unique case (cmd_t'(command))
            CMD_TICK:
            begin
                // advance the clock with wrap
                nxt.seconds = cur.seconds + 6'd1;
                if (nxt.seconds > SEC_MAX)
                begin
                    nxt.seconds          = 6'd0;
                    nxt.clk_time.minutes = cur.clk_time.minutes + 6'd1;
                end
                if (nxt.clk_time.minutes > MIN_MAX)
                begin
                    nxt.clk_time.minutes = 6'd0;
                    nxt.clk_time.hours   = cur.clk_time.hours + 5'd1;
                end
                if (nxt.clk_time.hours > HOUR_MAX)
                begin
                    nxt.clk_time.hours = 5'd0;
                end
                // alarm one first, its flags feed alarm two
                w0 = check_wake(cur.armed[0], cur.wake[0], nxt.clk_time,
                                cur.snooze, cur.trig, cur.counts[0], snooze_limit);
                w1 = check_wake(cur.armed[1], cur.wake[1], nxt.clk_time,
                                w0.snooze, w0.trig, cur.counts[1], snooze_limit);
                nxt.snooze    = w1.snooze;
                nxt.trig      = w1.trig;
                nxt.counts[0] = w0.count;
                nxt.counts[1] = w1.count;
                if (w0.sound || w1.sound)
                begin
                    sound = cur.tone ? SOUND_TONE : SOUND_RADIO;
                end
                shown = nxt.clk_time;
            end
            CMD_ADJUST:
            begin
                unique case (target)
                    TGT_CLOCK:
                    begin
                        nxt.clk_time = apply_step(cur.clk_time, step);
                        shown        = nxt.clk_time;
                    end
                    TGT_ALARM_ONE:
                    begin
                        nxt.wake[0] = apply_step(cur.wake[0], step);
                        shown       = nxt.wake[0];
                    end
                    TGT_ALARM_TWO:
                    begin
                        nxt.wake[1] = apply_step(cur.wake[1], step);
                        shown       = nxt.wake[1];
                    end
                    default: shown = cur.clk_time;
                endcase
            end
            CMD_TOGGLE:
            begin
                // flip arm state and sound source of an alarm
                if ((target == TGT_ALARM_ONE) || (target == TGT_ALARM_TWO))
                begin
                    if (cur.armed[sel])
                    begin
                        nxt.armed[sel] = 1'b0;
                        mute           = 1'b1;
                        nxt.trig       = 1'b0;
                        nxt.snooze     = 1'b0;
                    end
                    else
                    begin
                        nxt.armed[sel] = 1'b1;
                    end
                    nxt.tone = ~cur.tone;
                end
            end
            CMD_SNOOZE:
            begin
                mute       = 1'b1;
                nxt.snooze = 1'b1;
            end
            default: nxt = cur;
        endcase

        // assemble the result beat
        res.clock_hours     = nxt.clk_time.hours;
        res.clock_minutes   = nxt.clk_time.minutes;
        res.clock_seconds   = nxt.seconds;
        res.shown_value     = shown_of(shown);
        res.alarm_one_armed = nxt.armed[0];
        res.alarm_two_armed = nxt.armed[1];
        res.ringing_latched = nxt.trig;
        res.snoozing        = nxt.snooze;
        res.sound_start     = sound;
        res.tone_mute       = mute;
    end

endmodule

// ===== rtl/core/alarm_clock_with_snooze_top.sv =====
// Top level of the 24-hour alarm clock with two alarms and snooze.
// Depends on acws_pkg, acws_ifs (channel interfaces) and acws_eval.
//
//  channel   role   beat contents
//  -------   ----   -----------------------------------------------------
//  events    sink   command, target, step
//  status    source clock time, shown value, alarm flags, sound, mute
//  cfg_*     write  snooze_limit (8 bits), taken on any edge with cfg_we
//
// One event is taken per cycle. Each event is held in the input register,
// then the clock state and the status register update at the same edge,
// once the status register is free or its beat is taken.
// Reset clears the clock, alarms, flags and counters; snooze_limit resets
// to 20. A stalled status beat holds the input register, which then holds
// off further events; otherwise events flow at one per cycle.
module alarm_clock_with_snooze_top (
    input  logic              clk,
    input  logic              rst_n,
    acws_event_if.sink        events,
    acws_status_if.source     status,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata
);
    import acws_pkg::*;

    logic       in_vld_reg;
    logic [1:0] cmd_reg;
    logic [1:0] tgt_reg;
    logic [2:0] step_reg;
    logic [7:0] limit_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_vld_reg;
    logic       advance;

    // move the held event into the status register
    assign advance      = in_vld_reg && (!out_vld_reg || status.ready);
    assign events.ready = !in_vld_reg || advance;

    acws_eval u_eval (
        .cur          (state_reg),
        .snooze_limit (limit_reg),
        .command      (cmd_reg),
        .target       (tgt_reg),
        .step         (step_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    // snooze limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= SNOOZE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            in_vld_reg <= events.valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            cmd_reg  <= events.command;
            tgt_reg  <= events.target;
            step_reg <= events.step;
        end
    end

    // commit clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // status valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // status payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // drive the status beat
    assign status.valid           = out_vld_reg;
    assign status.clock_hours     = res_reg.clock_hours;
    assign status.clock_minutes   = res_reg.clock_minutes;
    assign status.clock_seconds   = res_reg.clock_seconds;
    assign status.shown_value     = res_reg.shown_value;
    assign status.alarm_one_armed = res_reg.alarm_one_armed;
    assign status.alarm_two_armed = res_reg.alarm_two_armed;
    assign status.ringing_latched = res_reg.ringing_latched;
    assign status.snoozing        = res_reg.snoozing;
    assign status.sound_start     = res_reg.sound_start;
    assign status.tone_mute       = res_reg.tone_mute;

    // clock state stays within wrap limits
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.clk_time.hours <= HOUR_MAX) && (state_reg.clk_time.minutes <= MIN_MAX)
        && (state_reg.seconds <= SEC_MAX))
        else $error("clock state out of range");

    // a muted beat never starts a sound
    a_mute_no_sound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.tone_mute) |-> (res_reg.sound_start == SOUND_NONE))
        else $error("mute and sound start in one beat");

    // held event does not touch the state while status stalls
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && !status.ready) |=> $stable(state_reg))
        else $error("state changed during stall");

    // status mirrors the state committed with it
    a_status_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_vld_reg && (res_reg.snoozing == state_reg.snooze)
                     && (res_reg.ringing_latched == state_reg.trig)))
        else $error("status beat disagrees with committed state");

endmodule
